### rtl/local_snv_window_normalizer_unit_assert.svh
// Assertion macros for the moving-window normalizer.
`ifndef LOCAL_SNV_WINDOW_NORMALIZER_UNIT_ASSERT_SVH
`define LOCAL_SNV_WINDOW_NORMALIZER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SNV_AST_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("snv assertion failed");
`define SNV_AST_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("snv assertion failed");
`else
`define SNV_AST_IMP(lbl, clk, rst_n, ante, cons)
`define SNV_AST_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/snv_pkg.sv
`default_nettype none
package snv_pkg;
	localparam int SAMPLE_W     = 16;
	localparam int OUT_W        = 20;
	localparam int FRAC_W       = 12;
	localparam int WW_W         = 6;
	localparam int MAX_WINDOW   = 63;
	localparam int MAX_ROW_DEF  = 1024;
	localparam int MAX_OUT_STEP = 32;
	localparam int NOUT_W       = 6;
	localparam int SUM_W        = 23;
	localparam int SQS_W        = 37;
	localparam int WQ_W         = 43;
	localparam int SS_W         = 46;
	localparam int NUM_W        = 24;
	localparam int D_W          = 44;
	localparam int ROOT_W       = D_W / 2;
	localparam int SREM_W       = ROOT_W + 2;
	localparam int MAG_W        = NUM_W + FRAC_W;
	localparam int DIVN_W       = MAG_W + 1;
	localparam int IT_W         = 6;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_CONSTANT = 2'd2;

	localparam logic [1:0] PAD_REFLECT  = 2'd0;
	localparam logic [1:0] PAD_EDGE     = 2'd1;
	localparam logic [1:0] PAD_CONSTANT = 2'd2;
	localparam logic [1:0] PAD_INVALID  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_XREAD, S_XCAP, S_BACK, S_SADDR, S_SDATA,
		S_CALC1, S_CALC2, S_NWAIT, S_OUTP
	} snv_state_t;

	typedef enum logic [2:0] {
		N_IDLE, N_SQRT, N_PREP, N_DIV, N_FIN
	} norm_state_t;

	typedef struct packed {
		logic [D_W-1:0]          d;
		logic signed [NUM_W-1:0] num;
		logic [WW_W-1:0]         w;
	} norm_req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic                    sat;
	} norm_res_t;
endpackage
`default_nettype wire

### rtl/snv_row_mem.sv
`default_nettype none
module snv_row_mem #(
	parameter int DEPTH = snv_pkg::MAX_ROW_DEF,
	parameter int AW    = 10
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [AW-1:0]                     waddr,
	input  wire logic signed [snv_pkg::SAMPLE_W-1:0] wdata,
	input  wire logic [AW-1:0]                     raddr,
	output logic signed [snv_pkg::SAMPLE_W-1:0]      rdata
);
	logic signed [snv_pkg::SAMPLE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/snv_norm_unit.sv
`default_nettype none
module snv_norm_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire snv_pkg::norm_req_t  req,
	output logic                     busy,
	output logic                     done,
	output snv_pkg::norm_res_t       res
);
	localparam int DW = snv_pkg::D_W;
	localparam int RW = snv_pkg::ROOT_W;
	localparam int SW = snv_pkg::SREM_W;
	localparam int NW = snv_pkg::DIVN_W;
	localparam int OW = snv_pkg::OUT_W;
	localparam int IW = snv_pkg::IT_W;
	localparam logic [NW-1:0] POS_LIM = NW'((64'd1 << (OW - 1)) - 64'd1);
	localparam logic [NW-1:0] NEG_LIM = NW'(64'd1 << (OW - 1));

	snv_pkg::norm_state_t state_q, state_d;

	logic [DW-1:0]                    d_q;
	logic [RW-1:0]                    root_q;
	logic [SW-1:0]                    srem_q;
	logic [RW-1:0]                    den_q;
	logic [NW-1:0]                    n_q;
	logic [NW-1:0]                    quo_q;
	logic [RW-1:0]                    drem_q;
	logic [snv_pkg::MAG_W-1:0]        mag_q;
	logic                             neg_q;
	logic [IW-1:0]                    it_q;
	logic                             done_q;
	snv_pkg::norm_res_t               res_q;

	logic [SW+1:0] rem_sh, trial;
	logic          sq_ge;
	logic [RW:0]   dsh;
	logic          dv_ge;
	logic [snv_pkg::NUM_W-1:0] num_abs;

	always_comb begin
		rem_sh  = {srem_q, d_q[DW-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		sq_ge   = rem_sh >= trial;
		dsh     = {drem_q, n_q[NW-1]};
		dv_ge   = dsh >= {1'b0, den_q};
		num_abs = req.num[snv_pkg::NUM_W-1] ? $unsigned(-req.num) : $unsigned(req.num);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			snv_pkg::N_IDLE: begin
				if (start) begin
					state_d = (req.d == '0) ? snv_pkg::N_PREP : snv_pkg::N_SQRT;
				end
			end
			snv_pkg::N_SQRT: begin
				if (it_q == IW'(1)) begin
					state_d = snv_pkg::N_PREP;
				end
			end
			snv_pkg::N_PREP: state_d = snv_pkg::N_DIV;
			snv_pkg::N_DIV: begin
				if (it_q == IW'(1)) begin
					state_d = snv_pkg::N_FIN;
				end
			end
			snv_pkg::N_FIN: state_d = snv_pkg::N_IDLE;
			default: state_d = snv_pkg::N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= snv_pkg::N_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == snv_pkg::N_FIN);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			snv_pkg::N_IDLE: begin
				if (start) begin
					d_q    <= req.d;
					root_q <= '0;
					srem_q <= '0;
					den_q  <= RW'(req.w);
					mag_q  <= {num_abs, {snv_pkg::FRAC_W{1'b0}}};
					neg_q  <= req.num[snv_pkg::NUM_W-1];
					it_q   <= IW'(RW);
				end
			end
			snv_pkg::N_SQRT: begin
				d_q  <= d_q << 2;
				it_q <= it_q - IW'(1);
				if (sq_ge) begin
					srem_q <= SW'(rem_sh - trial);
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					srem_q <= SW'(rem_sh);
					root_q <= {root_q[RW-2:0], 1'b0};
				end
				if (it_q == IW'(1)) begin
					den_q <= sq_ge ? {root_q[RW-2:0], 1'b1} : {root_q[RW-2:0], 1'b0};
				end
			end
			snv_pkg::N_PREP: begin
				n_q    <= NW'(mag_q) + NW'(den_q >> 1);
				quo_q  <= '0;
				drem_q <= '0;
				it_q   <= IW'(NW);
			end
			snv_pkg::N_DIV: begin
				n_q    <= n_q << 1;
				it_q   <= it_q - IW'(1);
				drem_q <= dv_ge ? RW'(dsh - {1'b0, den_q}) : RW'(dsh);
				quo_q  <= {quo_q[NW-2:0], dv_ge};
			end
			snv_pkg::N_FIN: begin
				if (neg_q) begin
					res_q.sat   <= quo_q > NEG_LIM;
					res_q.value <= (quo_q > NEG_LIM) ? $signed(NEG_LIM[OW-1:0])
						: $signed(-quo_q[OW-1:0]);
				end else begin
					res_q.sat   <= quo_q > POS_LIM;
					res_q.value <= (quo_q > POS_LIM) ? $signed(POS_LIM[OW-1:0])
						: $signed(quo_q[OW-1:0]);
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != snv_pkg::N_IDLE);
	assign done = done_q;
	assign res  = res_q;
endmodule
`default_nettype wire

### rtl/local_snv_window_normalizer_unit.sv
// Moving-window standard normal variate normalizer.
// Input channel (sample, row_end) carries one sample of a spectrum row per
// transfer; row_end marks the last sample. Output channel carries norm_value
// (Q.12), row_last, saturated and row_too_long, one transfer per position.
// Position j leaves once sample j+w/2 has arrived; the rest of the row leaves
// after the row_end transfer, at most 32 results per input transfer.
// Configuration: write cfg_data to register cfg_index (0 window width, 1 pad
// mode, 2 pad constant) while the block is idle; refused values are ignored.
// For each result the window is read from the row store one sample at a time,
// then a shared shift/subtract unit runs 22 square-root steps (none when the
// variance term is zero) and 37 division steps. in_ready is high only
// between items.
// A finished result waits in the output register; if the receiver stalls,
// the next result is held back in the unit until that register frees.
// Reset clears the row state and restores window 3, reflect padding, pad 0.
`default_nettype none
module local_snv_window_normalizer_unit #(
	parameter int MAX_ROW_LEN = snv_pkg::MAX_ROW_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [snv_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                                 row_end,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [snv_pkg::OUT_W-1:0]          norm_value,
	output logic                                      row_last,
	output logic                                      saturated,
	output logic                                      row_too_long,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [snv_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [snv_pkg::CFG_DATA_W-1:0]       cfg_data
);
	localparam int AW  = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
	localparam int CW  = $clog2(MAX_ROW_LEN + 1);
	localparam int KW  = ((CW > snv_pkg::WW_W) ? CW : snv_pkg::WW_W) + 2;
	localparam int MW  = CW + snv_pkg::WW_W;
	localparam int SMW = snv_pkg::SAMPLE_W;
	localparam int HW  = snv_pkg::WW_W - 1;

	snv_pkg::snv_state_t state_q, state_d;

	logic [CW-1:0]               cnt_q, nop_q;
	logic [snv_pkg::NOUT_W-1:0]  n_q;
	logic                        ovf_q, end_q;
	logic [snv_pkg::WW_W-1:0]    ww_q;
	logic [1:0]                  pm_q;
	logic signed [SMW-1:0]       pc_q;
	logic signed [SMW-1:0]       x_q;
	logic signed [KW-1:0]        k_q;
	logic [AW-1:0]               pos_q;
	logic                        dir_q;
	logic [HW-1:0]               bcnt_q;
	logic [snv_pkg::WW_W-1:0]    fcnt_q;
	logic                        use_const_q;
	logic signed [snv_pkg::SUM_W-1:0] sum_q;
	logic [snv_pkg::SQS_W-1:0]   sq_q;
	logic [snv_pkg::WQ_W-1:0]    wq_q;
	logic signed [snv_pkg::SS_W-1:0]  ss_q;
	logic signed [snv_pkg::NUM_W-1:0] nb_q;

	logic                        ov_q, rl_q, sat_q, rtl_q;
	logic signed [snv_pkg::OUT_W-1:0] nv_q;

	logic                        in_xfer, out_load, nu_start, nu_busy, nu_done;
	logic                        mem_we;
	logic [AW-1:0]               mem_raddr, sel_addr;
	logic                        sel_const;
	logic signed [SMW-1:0]       mem_rdata, v;
	logic signed [2*SMW-1:0]     v_ext, vsq;
	logic                        emit_ok, in_range;
	logic [AW-1:0]               last_idx, pos_bk, pos_fw;
	logic                        dir_bk, dir_fw, m_one;
	logic [HW-1:0]               half;
	logic signed [snv_pkg::SS_W-1:0]  sum_ext;
	logic signed [snv_pkg::NUM_W-1:0] w_s;
	snv_pkg::norm_req_t          nu_req;
	snv_pkg::norm_res_t          nu_res;

	assign half     = ww_q[snv_pkg::WW_W-1:1];
	assign in_xfer  = in_valid && in_ready;
	assign last_idx = AW'(cnt_q - CW'(1));
	assign m_one    = (cnt_q == CW'(1));
	assign emit_ok  = (n_q < snv_pkg::NOUT_W'(snv_pkg::MAX_OUT_STEP)) && (nop_q < cnt_q)
		&& (end_q || ((MW'(nop_q) + MW'(half)) < MW'(cnt_q)));
	assign in_range = !k_q[KW-1] && (k_q < $signed(KW'(cnt_q)));

	always_comb begin
		sel_const = 1'b0;
		sel_addr  = k_q[AW-1:0];
		if (!in_range) begin
			unique case (pm_q)
				snv_pkg::PAD_EDGE:     sel_addr = k_q[KW-1] ? '0 : last_idx;
				snv_pkg::PAD_REFLECT:  sel_addr = pos_q;
				snv_pkg::PAD_CONSTANT: sel_const = 1'b1;
				default:               sel_const = 1'b1;
			endcase
		end
	end

	always_comb begin
		pos_bk = pos_q;
		dir_bk = dir_q;
		pos_fw = pos_q;
		dir_fw = dir_q;
		if (!m_one) begin
			if (dir_q) begin
				if (pos_q == '0) begin
					pos_bk = AW'(1);
					dir_bk = 1'b0;
				end else begin
					pos_bk = pos_q - AW'(1);
				end
				if (pos_q == last_idx) begin
					pos_fw = last_idx - AW'(1);
					dir_fw = 1'b0;
				end else begin
					pos_fw = pos_q + AW'(1);
				end
			end else begin
				if (pos_q == last_idx) begin
					pos_bk = last_idx - AW'(1);
					dir_bk = 1'b1;
				end else begin
					pos_bk = pos_q + AW'(1);
				end
				if (pos_q == '0) begin
					pos_fw = AW'(1);
					dir_fw = 1'b1;
				end else begin
					pos_fw = pos_q - AW'(1);
				end
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		nu_start  = 1'b0;
		out_load  = 1'b0;
		mem_raddr = sel_addr;
		unique case (state_q)
			snv_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = snv_pkg::S_CHECK;
				end
			end
			snv_pkg::S_CHECK: state_d = emit_ok ? snv_pkg::S_XREAD : snv_pkg::S_IDLE;
			snv_pkg::S_XREAD: begin
				mem_raddr = nop_q[AW-1:0];
				state_d   = snv_pkg::S_XCAP;
			end
			snv_pkg::S_XCAP: state_d = snv_pkg::S_BACK;
			snv_pkg::S_BACK: begin
				if (bcnt_q == '0) begin
					state_d = snv_pkg::S_SADDR;
				end
			end
			snv_pkg::S_SADDR: state_d = snv_pkg::S_SDATA;
			snv_pkg::S_SDATA: begin
				state_d = (fcnt_q == snv_pkg::WW_W'(1)) ? snv_pkg::S_CALC1 : snv_pkg::S_SADDR;
			end
			snv_pkg::S_CALC1: state_d = snv_pkg::S_CALC2;
			snv_pkg::S_CALC2: begin
				nu_start = 1'b1;
				state_d  = snv_pkg::S_NWAIT;
			end
			snv_pkg::S_NWAIT: begin
				if (nu_done) begin
					state_d = snv_pkg::S_OUTP;
				end
			end
			snv_pkg::S_OUTP: begin
				if (!ov_q || out_ready) begin
					out_load = 1'b1;
					state_d  = snv_pkg::S_CHECK;
				end
			end
			default: state_d = snv_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= snv_pkg::S_IDLE;
			cnt_q   <= '0;
			nop_q   <= '0;
			n_q     <= '0;
			ovf_q   <= 1'b0;
			end_q   <= 1'b0;
			ov_q    <= 1'b0;
			ww_q    <= snv_pkg::WW_W'(3);
			pm_q    <= snv_pkg::PAD_REFLECT;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				end_q <= row_end;
				n_q   <= '0;
				if (cnt_q < CW'(MAX_ROW_LEN)) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == snv_pkg::S_CHECK && !emit_ok && end_q) begin
				cnt_q <= '0;
				nop_q <= '0;
				ovf_q <= 1'b0;
				end_q <= 1'b0;
			end
			if (out_load) begin
				nop_q <= nop_q + CW'(1);
				n_q   <= n_q + snv_pkg::NOUT_W'(1);
				ov_q  <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					snv_pkg::REG_WINDOW_WIDTH: begin
						if (cfg_data[0] && cfg_data[snv_pkg::WW_W-1:0] >= snv_pkg::WW_W'(3)
							&& cfg_data[snv_pkg::WW_W-1:0] <= snv_pkg::WW_W'(snv_pkg::MAX_WINDOW)) begin
							ww_q <= cfg_data[snv_pkg::WW_W-1:0];
						end
					end
					snv_pkg::REG_PAD_MODE: begin
						if (cfg_data[1:0] != snv_pkg::PAD_INVALID) begin
							pm_q <= cfg_data[1:0];
						end
					end
					snv_pkg::REG_PAD_CONSTANT: pc_q <= $signed(cfg_data[SMW-1:0]);
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		v       = use_const_q ? pc_q : mem_rdata;
		v_ext   = (2*SMW)'(v);
		vsq     = v_ext * v_ext;
		sum_ext = snv_pkg::SS_W'(sum_q);
		w_s     = $signed(snv_pkg::NUM_W'(ww_q));
	end

	always_ff @(posedge clk) begin
		case (state_q)
			snv_pkg::S_XCAP: begin
				x_q    <= mem_rdata;
				k_q    <= $signed(KW'(nop_q));
				pos_q  <= nop_q[AW-1:0];
				dir_q  <= 1'b1;
				bcnt_q <= half;
				sum_q  <= '0;
				sq_q   <= '0;
				fcnt_q <= ww_q;
			end
			snv_pkg::S_BACK: begin
				if (bcnt_q != '0) begin
					k_q    <= k_q - KW'(1);
					pos_q  <= pos_bk;
					dir_q  <= dir_bk;
					bcnt_q <= bcnt_q - HW'(1);
				end
			end
			snv_pkg::S_SADDR: use_const_q <= sel_const;
			snv_pkg::S_SDATA: begin
				sum_q  <= sum_q + snv_pkg::SUM_W'(v);
				sq_q   <= sq_q + snv_pkg::SQS_W'($unsigned(vsq));
				fcnt_q <= fcnt_q - snv_pkg::WW_W'(1);
				k_q    <= k_q + KW'(1);
				pos_q  <= pos_fw;
				dir_q  <= dir_fw;
			end
			snv_pkg::S_CALC1: begin
				wq_q <= snv_pkg::WQ_W'(ww_q) * snv_pkg::WQ_W'(sq_q);
				ss_q <= sum_ext * sum_ext;
				nb_q <= w_s * snv_pkg::NUM_W'(x_q) - snv_pkg::NUM_W'(sum_q);
			end
			default: ;
		endcase
		if (out_load) begin
			nv_q  <= nu_res.value;
			sat_q <= nu_res.sat;
			rl_q  <= end_q && (nop_q == cnt_q - CW'(1));
			rtl_q <= ovf_q;
		end
	end

	always_comb begin
		nu_req.d   = snv_pkg::D_W'(wq_q) - snv_pkg::D_W'($unsigned(ss_q));
		nu_req.num = nb_q;
		nu_req.w   = ww_q;
	end

	assign mem_we = in_xfer && (cnt_q < CW'(MAX_ROW_LEN));

	snv_row_mem #(
		.DEPTH(MAX_ROW_LEN),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(sample),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	snv_norm_unit u_norm (
		.clk   (clk),
		.arst_n(arst_n),
		.start (nu_start),
		.req   (nu_req),
		.busy  (nu_busy),
		.done  (nu_done),
		.res   (nu_res)
	);

	assign out_valid    = ov_q;
	assign norm_value   = nv_q;
	assign row_last     = rl_q;
	assign saturated    = sat_q;
	assign row_too_long = rtl_q;

`include "local_snv_window_normalizer_unit_assert.svh"
	`SNV_AST_IMP(a_busy_wait, clk, arst_n, nu_busy, state_q == snv_pkg::S_NWAIT)
	`SNV_AST_NXT(a_start_busy, clk, arst_n, nu_start, nu_busy)
	`SNV_AST_IMP(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= CW'(MAX_ROW_LEN))
	`SNV_AST_IMP(a_nout_max, clk, arst_n, 1'b1, n_q <= snv_pkg::NOUT_W'(snv_pkg::MAX_OUT_STEP))
	`SNV_AST_IMP(a_nop_cnt, clk, arst_n, state_q == snv_pkg::S_IDLE, nop_q <= cnt_q)
endmodule
`default_nettype wire

### tb/snv_result_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module snv_result_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_ready,
	input  wire logic signed [snv_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                                 row_end,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_ready,
	input  wire logic signed [snv_pkg::OUT_W-1:0]     norm_value,
	input  wire logic                                 row_last,
	input  wire logic                                 saturated,
	input  wire logic                                 row_too_long,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [snv_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [snv_pkg::CFG_DATA_W-1:0]       cfg_data,
	output int                                        pending,
	output int                                        errors
);
	localparam int ROW_DEPTH = snv_pkg::MAX_ROW_DEF;
	localparam longint OUT_HI = (1 <<< (snv_pkg::OUT_W - 1)) - 1;
	localparam longint OUT_LO = -(1 <<< (snv_pkg::OUT_W - 1));

	typedef struct {
		logic signed [snv_pkg::OUT_W-1:0] value;
		logic                             last;
		logic                             sat;
		logic                             too_long;
	} snv_result_t;

	snv_result_t norm_q[$];

	logic [snv_pkg::WW_W-1:0]            win_w;
	logic [1:0]                          pad_sel;
	logic signed [snv_pkg::SAMPLE_W-1:0] pad_val;
	longint                              row_mem [ROW_DEPTH];
	int                                  rx_count;
	int                                  emit_pos;
	bit                                  dropped;

	function automatic longint padded_at(longint k, longint m);
		longint period;
		longint off;
		if (k >= 0 && k < m) return row_mem[k];
		if (pad_sel == snv_pkg::PAD_CONSTANT) return pad_val;
		if (pad_sel == snv_pkg::PAD_EDGE) return k < 0 ? row_mem[0] : row_mem[m-1];
		if (m == 1) return row_mem[0];
		period = 2 * (m - 1);
		off = k % period;
		if (off < 0) off += period;
		if (off >= m) off = period - off;
		return row_mem[off];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic longint round_div(longint num, longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = num < 0 ? longint'(-num) : longint'(num);
		q = (mag + den / 2) / den;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic snv_result_t normalize_at(longint j, longint m, bit last);
		snv_result_t r;
		longint w;
		longint half;
		longint s;
		longint q;
		longint v;
		longint d;
		longint num;
		longint res;
		w = win_w;
		half = w / 2;
		s = 0;
		q = 0;
		for (longint i = -half; i <= half; i++) begin
			v = padded_at(j + i, m);
			s += v;
			q += v * v;
		end
		d = w * q - s * s;
		num = (w * row_mem[j] - s) * 4096;
		if (d <= 0) res = round_div(num, w);
		else res = round_div(num, int_sqrt(d));
		r.sat = 1'b0;
		if (res > OUT_HI) begin
			res = OUT_HI;
			r.sat = 1'b1;
		end
		if (res < OUT_LO) begin
			res = OUT_LO;
			r.sat = 1'b1;
		end
		r.value = res[snv_pkg::OUT_W-1:0];
		r.last = last;
		r.too_long = dropped;
		return r;
	endfunction

	task automatic accept_sample(logic signed [snv_pkg::SAMPLE_W-1:0] s, logic e);
		int n;
		int half;
		n = 0;
		half = win_w / 2;
		if (rx_count < ROW_DEPTH) begin
			row_mem[rx_count] = s;
			rx_count++;
		end else begin
			dropped = 1'b1;
		end
		while (n < snv_pkg::MAX_OUT_STEP && emit_pos < rx_count
			&& (e || emit_pos + half < rx_count)) begin
			norm_q.push_back(normalize_at(emit_pos, rx_count, e && emit_pos == rx_count - 1));
			emit_pos++;
			n++;
		end
		if (e) begin
			rx_count = 0;
			emit_pos = 0;
			dropped = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		snv_result_t exp_r;
		if (!arst_n) begin
			win_w = 6'd3;
			pad_sel = snv_pkg::PAD_REFLECT;
			pad_val = '0;
			rx_count = 0;
			emit_pos = 0;
			dropped = 1'b0;
			norm_q.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					snv_pkg::REG_WINDOW_WIDTH: begin
						if (cfg_data[snv_pkg::WW_W-1:0] >= 3
							&& cfg_data[snv_pkg::WW_W-1:0] <= snv_pkg::MAX_WINDOW
							&& cfg_data[0])
							win_w = cfg_data[snv_pkg::WW_W-1:0];
					end
					snv_pkg::REG_PAD_MODE: begin
						if (cfg_data[1:0] != snv_pkg::PAD_INVALID) pad_sel = cfg_data[1:0];
					end
					snv_pkg::REG_PAD_CONSTANT: pad_val = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) accept_sample(sample, row_end);
			if (out_valid && out_ready) begin
				if (norm_q.size() == 0) begin
					$display("%0t norm_value expected none got %0d", $time, norm_value);
					errors++;
				end else begin
					exp_r = norm_q.pop_front();
					if (norm_value !== exp_r.value) begin
						$display("%0t norm_value expected %0d got %0d", $time, exp_r.value,
							norm_value);
						errors++;
					end
					if (row_last !== exp_r.last) begin
						$display("%0t row_last expected %0d got %0d", $time, exp_r.last, row_last);
						errors++;
					end
					if (saturated !== exp_r.sat) begin
						$display("%0t saturated expected %0d got %0d", $time, exp_r.sat,
							saturated);
						errors++;
					end
					if (row_too_long !== exp_r.too_long) begin
						$display("%0t row_too_long expected %0d got %0d", $time, exp_r.too_long,
							row_too_long);
						errors++;
					end
				end
			end
			pending = norm_q.size();
		end
	end
endmodule
`default_nettype wire

### tb/tb_local_snv_window_normalizer_unit.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_local_snv_window_normalizer_unit;
	localparam logic [snv_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int ROW_FLAT  = 0;
	localparam int ROW_RAMP  = 1;
	localparam int ROW_WIDE  = 2;
	localparam int ROW_NARROW = 3;
	localparam int ROW_EXTREME = 4;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	logic signed [snv_pkg::SAMPLE_W-1:0]  sample;
	logic                                 row_end;
	logic                                 out_valid;
	logic                                 out_ready;
	logic signed [snv_pkg::OUT_W-1:0]     norm_value;
	logic                                 row_last;
	logic                                 saturated;
	logic                                 row_too_long;
	logic                                 cfg_wr_en;
	logic [snv_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [snv_pkg::CFG_DATA_W-1:0]       cfg_data;
	int                                   pending;
	int                                   errors;
	int                                   sent;
	bit                                   quiet;
	bit                                   hold_req;

	local_snv_window_normalizer_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample), .row_end(row_end),
		.out_valid(out_valid), .out_ready(out_ready), .norm_value(norm_value),
		.row_last(row_last), .saturated(saturated), .row_too_long(row_too_long),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	snv_result_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample), .row_end(row_end),
		.out_valid(out_valid), .out_ready(out_ready), .norm_value(norm_value),
		.row_last(row_last), .saturated(saturated), .row_too_long(row_too_long),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .errors(errors)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#40ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (2000) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	task automatic send_sample(logic signed [snv_pkg::SAMPLE_W-1:0] s, logic e);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		row_end <= e;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [snv_pkg::CFG_IDX_W-1:0] idx,
		logic [snv_pkg::CFG_DATA_W-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic signed [snv_pkg::SAMPLE_W-1:0] row_value(int shape, int idx,
		int base);
		case (shape)
			ROW_FLAT:    return base;
			ROW_RAMP:    return base + idx * 37;
			ROW_NARROW:  return base + $signed($urandom_range(0, 6)) - 3;
			ROW_EXTREME: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default:     return $urandom;
		endcase
	endfunction

	task automatic send_row(int len, int shape);
		int base;
		base = $signed($urandom_range(0, 40000)) - 20000;
		for (int i = 0; i < len; i++) send_sample(row_value(shape, i, base), i == len - 1);
	endtask

	initial begin
		int rows;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		row_end = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = snv_pkg::REG_WINDOW_WIDTH;
		cfg_data = '0;
		sent = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh0000, 1'b1);
		send_row(4, ROW_FLAT);
		wait_idle();
		write_reg(snv_pkg::REG_WINDOW_WIDTH, 16'd63);
		write_reg(snv_pkg::REG_PAD_MODE, snv_pkg::PAD_EDGE);
		send_row(5, ROW_EXTREME);
		wait_idle();
		write_reg(snv_pkg::REG_PAD_MODE, snv_pkg::PAD_CONSTANT);
		write_reg(snv_pkg::REG_PAD_CONSTANT, 16'h8000);
		send_row(3, ROW_RAMP);
		wait_idle();
		write_reg(snv_pkg::REG_PAD_CONSTANT, 16'h7fff);
		write_reg(snv_pkg::REG_WINDOW_WIDTH, 16'd5);
		write_reg(snv_pkg::REG_WINDOW_WIDTH, 16'd4);
		write_reg(snv_pkg::REG_WINDOW_WIDTH, 16'h0041);
		write_reg(snv_pkg::REG_WINDOW_WIDTH, 16'd1);
		write_reg(snv_pkg::REG_PAD_MODE, snv_pkg::PAD_INVALID);
		write_reg(REG_UNUSED, 16'hffff);
		send_row(4, ROW_WIDE);

		rows = 0;
		while (sent < 380) begin
			wait_idle();
			write_reg(snv_pkg::REG_WINDOW_WIDTH, 2 * $urandom_range(1, 31) + 1);
			write_reg(snv_pkg::REG_PAD_MODE, $urandom_range(0, 2));
			write_reg(snv_pkg::REG_PAD_CONSTANT, $urandom);
			repeat ($urandom_range(1, 2)) begin
				if (rows == 6) hold_req = 1'b1;
				send_row($urandom_range(0, 3) == 0 ? $urandom_range(1, 4)
					: $urandom_range(5, 40), $urandom_range(ROW_FLAT, ROW_EXTREME));
				rows++;
			end
		end

		wait_idle();
		quiet = 1'b1;
		write_reg(snv_pkg::REG_WINDOW_WIDTH, 16'd3);
		write_reg(snv_pkg::REG_PAD_MODE, snv_pkg::PAD_REFLECT);
		send_row(30, ROW_WIDE);
		send_row(20, ROW_RAMP);
		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (300) @(negedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
